FILE: rtl/core/lfps_pkg.sv
// shared constants, types and register codes for the line-follow pid steering unit
`default_nettype none

package lfps_pkg;

  localparam int IntegralLimit = 2000;

  localparam int PosWidth       = 8;
  localparam int DerivWidth     = PosWidth + 1;
  localparam int IntegWidth     = $clog2(IntegralLimit + 1) + 1;
  localparam int SumWidth       = ((IntegWidth > PosWidth) ? IntegWidth : PosWidth) + 1;

  localparam int GainPropWidth  = 12;
  localparam int GainIntegWidth = 10;
  localparam int GainDerivWidth = 14;
  localparam int BaseWidth      = 8;
  localparam int DutyWidth      = 8;
  localparam int SteerWidth     = 16;
  localparam int FracBits       = 8;

  // gains get an extra zero bit so they multiply as signed values
  localparam int ProdPropWidth  = GainPropWidth + 1 + PosWidth;
  localparam int ProdIntegWidth = GainIntegWidth + 1 + IntegWidth;
  localparam int ProdDerivWidth = GainDerivWidth + 1 + DerivWidth;
  localparam int ProdPiWidth    = (ProdPropWidth > ProdIntegWidth) ? ProdPropWidth
                                                                   : ProdIntegWidth;
  localparam int ProdMaxWidth   = (ProdPiWidth > ProdDerivWidth) ? ProdPiWidth
                                                                 : ProdDerivWidth;
  localparam int AccWidth       = ProdMaxWidth + 2;
  localparam int QuotWidth      = AccWidth - FracBits;

  localparam int ApbAddrWidth   = 4;
  localparam int ApbDataWidth   = 32;

  localparam logic [PosWidth-1:0] NoLineCode = 8'h7F;

  localparam logic [GainPropWidth-1:0]  GainPropReset  = 12'd1459;
  localparam logic [GainIntegWidth-1:0] GainIntegReset = 10'd20;
  localparam logic [GainDerivWidth-1:0] GainDerivReset = 14'd5120;
  localparam logic [BaseWidth-1:0]      BaseSpeedReset = 8'd200;

  typedef enum logic [1:0] {
    RegGainProp  = 2'd0,
    RegGainInteg = 2'd1,
    RegGainDeriv = 2'd2,
    RegBaseSpeed = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [GainPropWidth-1:0]  gain_prop;
    logic [GainIntegWidth-1:0] gain_integ;
    logic [GainDerivWidth-1:0] gain_deriv;
    logic [BaseWidth-1:0]      base_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [PosWidth-1:0]   err;
    logic signed [IntegWidth-1:0] integ;
    logic signed [DerivWidth-1:0] deriv;
  } terms_t;

endpackage

`default_nettype wire

FILE: rtl/core/line_follow_pid_steering_unit.sv
// top level of the line-follow pid steering unit
//
// one line-position sample per request on the input channel (in_valid_i,
// in_stall_o, position_i); the code 0x7f means no line, in which case the
// last good sample is reused and the integral, derivative and history hold.
// one result per request on the output channel (out_valid_o, out_stall_i):
// left and right motor duty and the signed steering correction.
// gains and base speed sit behind an apb port and are to be written only
// while idle; this binds the user, as the block leaves it unchecked.
// three register stages: error and state update, gain products and sum,
// then truncation, saturation and duty clamp into the output register.
// a new request is taken every cycle unless the receiver stalls;
// throughput is one request per cycle, set by the three-stage pipeline
// with one multiplier per gain.
// when the receiver stalls, the output holds and each stage fills in turn;
// in_stall_o rises once all three stages hold a result.
// reset clears history, integral, derivative and stage valids, and loads the
// default gains and base speed.
`default_nettype none

module line_follow_pid_steering_unit import lfps_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [PosWidth-1:0]   position_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [DutyWidth-1:0]         left_duty_o,
  output logic [DutyWidth-1:0]         right_duty_o,
  output logic signed [SteerWidth-1:0] steer_value_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ApbAddrWidth-1:0]      paddr,
  input  logic [ApbDataWidth-1:0]      pwdata,
  output logic [ApbDataWidth-1:0]      prdata,
  output logic                         pready
);

  cfg_t                       cfg;
  terms_t                     terms;
  logic                       terms_valid, terms_ready;
  logic signed [AccWidth-1:0] acc;
  logic                       acc_valid, acc_ready;

  lfps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfps_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .position_i    (position_i),
    .terms_valid_o (terms_valid),
    .terms_ready_i (terms_ready),
    .terms_o       (terms)
  );

  lfps_mac u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .terms_valid_i (terms_valid),
    .terms_ready_o (terms_ready),
    .terms_i       (terms),
    .acc_valid_o   (acc_valid),
    .acc_ready_i   (acc_ready),
    .acc_o         (acc)
  );

  lfps_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_speed_i  (cfg.base_speed),
    .acc_valid_i   (acc_valid),
    .acc_ready_o   (acc_ready),
    .acc_i         (acc),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_duty_o   (left_duty_o),
    .right_duty_o  (right_duty_o),
    .steer_value_o (steer_value_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lfps_regs.sv
// apb configuration registers: gains and base speed
`default_nettype none

module lfps_regs import lfps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ApbAddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop  <= GainPropReset;
      cfg_q.gain_integ <= GainIntegReset;
      cfg_q.gain_deriv <= GainDerivReset;
      cfg_q.base_speed <= BaseSpeedReset;
    end else if (wr_en) begin
      case (idx)
        RegGainProp:  cfg_q.gain_prop  <= pwdata[GainPropWidth-1:0];
        RegGainInteg: cfg_q.gain_integ <= pwdata[GainIntegWidth-1:0];
        RegGainDeriv: cfg_q.gain_deriv <= pwdata[GainDerivWidth-1:0];
        RegBaseSpeed: cfg_q.base_speed <= pwdata[BaseWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegGainProp:  prdata = ApbDataWidth'(cfg_q.gain_prop);
      RegGainInteg: prdata = ApbDataWidth'(cfg_q.gain_integ);
      RegGainDeriv: prdata = ApbDataWidth'(cfg_q.gain_deriv);
      RegBaseSpeed: prdata = ApbDataWidth'(cfg_q.base_speed);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/lfps_state.sv
// input stage: error select, history, integral and derivative state
`default_nettype none

module lfps_state import lfps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [PosWidth-1:0] position_i,
  output logic                       terms_valid_o,
  input  logic                       terms_ready_i,
  output terms_t                     terms_o
);

  localparam logic signed [SumWidth-1:0]   SumMax   = SumWidth'(IntegralLimit);
  localparam logic signed [SumWidth-1:0]   SumMin   = -SumMax;
  localparam logic signed [IntegWidth-1:0] IntegMax = IntegWidth'(IntegralLimit);
  localparam logic signed [IntegWidth-1:0] IntegMin = -IntegMax;

  logic signed [PosWidth-1:0]   hist_newest_q, hist_middle_q, hist_oldest_q;
  logic signed [IntegWidth-1:0] integ_q, integ_d;
  logic signed [DerivWidth-1:0] deriv_q, deriv_d;
  logic signed [SumWidth-1:0]   integ_sum;
  logic                         valid_q;
  logic                         stage_ready;
  logic                         accept;
  logic                         no_line;
  terms_t                       terms_q, terms_d;

  assign stage_ready = !valid_q || terms_ready_i;
  assign in_stall_o  = !stage_ready;
  assign accept      = in_valid_i && stage_ready;
  assign no_line     = $unsigned(position_i) == NoLineCode;

  assign integ_sum = SumWidth'(integ_q) + SumWidth'(position_i);
  assign deriv_d   = DerivWidth'(position_i) - DerivWidth'(hist_oldest_q);

  always_comb begin
    if (integ_sum > SumMax) begin
      integ_d = IntegMax;
    end else if (integ_sum < SumMin) begin
      integ_d = IntegMin;
    end else begin
      integ_d = integ_sum[IntegWidth-1:0];
    end
  end

  // no line: last good sample stands in, state frozen
  always_comb begin
    if (no_line) begin
      terms_d.err   = hist_newest_q;
      terms_d.integ = integ_q;
      terms_d.deriv = deriv_q;
    end else begin
      terms_d.err   = position_i;
      terms_d.integ = integ_d;
      terms_d.deriv = deriv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_newest_q <= '0;
      hist_middle_q <= '0;
      hist_oldest_q <= '0;
      integ_q       <= '0;
      deriv_q       <= '0;
    end else if (accept && !no_line) begin
      hist_newest_q <= position_i;
      hist_middle_q <= hist_newest_q;
      hist_oldest_q <= hist_middle_q;
      integ_q       <= integ_d;
      deriv_q       <= deriv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (stage_ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      terms_q <= terms_d;
    end
  end

  assign terms_valid_o = valid_q;
  assign terms_o       = terms_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= IntegMax) && (integ_q >= IntegMin))
    else $error("integral outside its limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && no_line) |=> ($stable(hist_newest_q) && $stable(hist_oldest_q) &&
                             $stable(integ_q) && $stable(deriv_q)))
    else $error("state moved on a no-line request");

endmodule

`default_nettype wire

FILE: rtl/core/lfps_mac.sv
// product stage: three gain products summed into the steering accumulator
`default_nettype none

module lfps_mac import lfps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       terms_valid_i,
  output logic                       terms_ready_o,
  input  terms_t                     terms_i,
  output logic                       acc_valid_o,
  input  logic                       acc_ready_i,
  output logic signed [AccWidth-1:0] acc_o
);

  logic signed [ProdPropWidth-1:0]  prod_p;
  logic signed [ProdIntegWidth-1:0] prod_i;
  logic signed [ProdDerivWidth-1:0] prod_d;
  logic signed [AccWidth-1:0]       acc_q, acc_d;
  logic                             valid_q;
  logic                             stage_ready;

  assign prod_p = $signed({1'b0, cfg_i.gain_prop})  * terms_i.err;
  assign prod_i = $signed({1'b0, cfg_i.gain_integ}) * terms_i.integ;
  assign prod_d = $signed({1'b0, cfg_i.gain_deriv}) * terms_i.deriv;
  assign acc_d  = AccWidth'(prod_p) + AccWidth'(prod_i) + AccWidth'(prod_d);

  assign stage_ready   = !valid_q || acc_ready_i;
  assign terms_ready_o = stage_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (stage_ready) begin
      valid_q <= terms_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready && terms_valid_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_valid_o = valid_q;
  assign acc_o       = acc_q;

endmodule

`default_nettype wire

FILE: rtl/core/lfps_out.sv
// result stage: truncate, saturate steering and clamp both duties
`default_nettype none

module lfps_out import lfps_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [BaseWidth-1:0]         base_speed_i,
  input  logic                         acc_valid_i,
  output logic                         acc_ready_o,
  input  logic signed [AccWidth-1:0]   acc_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [DutyWidth-1:0]         left_duty_o,
  output logic [DutyWidth-1:0]         right_duty_o,
  output logic signed [SteerWidth-1:0] steer_value_o
);

  localparam int DutySumWidth = SteerWidth + 2;
  localparam logic signed [QuotWidth-1:0] SteerMax = QuotWidth'((1 << (SteerWidth - 1)) - 1);
  localparam logic signed [QuotWidth-1:0] SteerMin = -SteerMax - QuotWidth'(1);
  localparam logic signed [DutySumWidth-1:0] DutyMax = DutySumWidth'((1 << DutyWidth) - 1);

  logic signed [QuotWidth-1:0]    quot_floor, quot;
  logic                           round_up;
  logic signed [SteerWidth-1:0]   steer;
  logic signed [DutySumWidth-1:0] base_ext, left_sum, right_sum;
  logic [DutyWidth-1:0]           left_d, right_d;
  logic [DutyWidth-1:0]           left_q, right_q;
  logic signed [SteerWidth-1:0]   steer_q;
  logic                           valid_q;
  logic                           stage_ready;

  // arithmetic shift floors, so negative values with a fraction step back up
  assign quot_floor = QuotWidth'(acc_i >>> FracBits);
  assign round_up   = acc_i[AccWidth-1] && (|acc_i[FracBits-1:0]);
  assign quot       = quot_floor + $signed(QuotWidth'(round_up));

  always_comb begin
    if (quot > SteerMax) begin
      steer = SteerMax[SteerWidth-1:0];
    end else if (quot < SteerMin) begin
      steer = SteerMin[SteerWidth-1:0];
    end else begin
      steer = quot[SteerWidth-1:0];
    end
  end

  assign base_ext  = $signed({{(DutySumWidth - BaseWidth){1'b0}}, base_speed_i});
  assign left_sum  = base_ext + DutySumWidth'(steer);
  assign right_sum = base_ext - DutySumWidth'(steer);

  always_comb begin
    if (left_sum < 0) begin
      left_d = '0;
    end else if (left_sum > DutyMax) begin
      left_d = '1;
    end else begin
      left_d = left_sum[DutyWidth-1:0];
    end
    if (right_sum < 0) begin
      right_d = '0;
    end else if (right_sum > DutyMax) begin
      right_d = '1;
    end else begin
      right_d = right_sum[DutyWidth-1:0];
    end
  end

  assign stage_ready = !valid_q || !out_stall_i;
  assign acc_ready_o = stage_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (stage_ready) begin
      valid_q <= acc_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready && acc_valid_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      steer_q <= steer;
    end
  end

  assign out_valid_o   = valid_q;
  assign left_duty_o   = left_q;
  assign right_duty_o  = right_q;
  assign steer_value_o = steer_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (steer_value_o > 0)) |-> (left_duty_o >= right_duty_o))
    else $error("positive steering with left duty below right duty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (steer_value_o < 0)) |-> (left_duty_o <= right_duty_o))
    else $error("negative steering with left duty above right duty");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for the line-follow pid steering unit: random samples against a local predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfps_pkg::*;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic signed [PosWidth-1:0]   position_i  = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [DutyWidth-1:0]         left_duty_o;
  logic [DutyWidth-1:0]         right_duty_o;
  logic signed [SteerWidth-1:0] steer_value_o;
  logic                         psel        = 1'b0;
  logic                         penable     = 1'b0;
  logic                         pwrite      = 1'b0;
  logic [ApbAddrWidth-1:0]      paddr       = '0;
  logic [ApbDataWidth-1:0]      pwdata      = '0;
  logic [ApbDataWidth-1:0]      prdata;
  logic                         pready;

  line_follow_pid_steering_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    logic [DutyWidth-1:0]         left;
    logic [DutyWidth-1:0]         right;
    logic signed [SteerWidth-1:0] steer;
  } drive_cmd_t;

  drive_cmd_t drive_q[$];

  // local copy of the gains and the controller state
  logic [GainPropWidth-1:0]     kp   = GainPropReset;
  logic [GainIntegWidth-1:0]    ki   = GainIntegReset;
  logic [GainDerivWidth-1:0]    kd   = GainDerivReset;
  logic [BaseWidth-1:0]         base = BaseSpeedReset;
  logic signed [PosWidth-1:0]   hist_new  = '0;
  logic signed [PosWidth-1:0]   hist_mid  = '0;
  logic signed [PosWidth-1:0]   hist_old  = '0;
  logic signed [IntegWidth-1:0] integ_acc = '0;
  logic signed [DerivWidth-1:0] deriv_acc = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int gain_settings = 0;

  function automatic drive_cmd_t predict_drive(logic [PosWidth-1:0] pos);
    logic signed [PosWidth-1:0] err;
    int isum;
    longint acc, steer, l, r;
    drive_cmd_t cmd;
    if (pos == NoLineCode) begin
      // no line: steer on the last good sample, everything else holds
      err = hist_new;
    end else begin
      err = pos;
      deriv_acc = DerivWidth'(int'(err) - int'(hist_old));
      isum = int'(integ_acc) + int'(err);
      if (isum > IntegralLimit) isum = IntegralLimit;
      else if (isum < -IntegralLimit) isum = -IntegralLimit;
      integ_acc = IntegWidth'(isum);
      hist_old = hist_mid;
      hist_mid = hist_new;
      hist_new = err;
    end
    acc = longint'(kp) * longint'(err) + longint'(ki) * longint'(integ_acc)
        + longint'(kd) * longint'(deriv_acc);
    steer = acc / 256;
    if (steer > 32767) steer = 32767;
    else if (steer < -32768) steer = -32768;
    l = longint'(base) + steer;
    r = longint'(base) - steer;
    if (l < 0) l = 0;
    else if (l > 255) l = 255;
    if (r < 0) r = 0;
    else if (r > 255) r = 255;
    cmd.left  = l[DutyWidth-1:0];
    cmd.right = r[DutyWidth-1:0];
    cmd.steer = steer[SteerWidth-1:0];
    return cmd;
  endfunction

  task automatic report_error(string msg);
    $display("tb: %0t %s", $realtime, msg);
    errors++;
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    drive_cmd_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        report_error($sformatf("unexpected result left %0d right %0d steer %0d",
                               left_duty_o, right_duty_o, steer_value_o));
      end else begin
        want = drive_q.pop_front();
        results_checked++;
        if (left_duty_o !== want.left)
          report_error($sformatf("left_duty got %0d want %0d", left_duty_o, want.left));
        if (right_duty_o !== want.right)
          report_error($sformatf("right_duty got %0d want %0d", right_duty_o, want.right));
        if (steer_value_o !== want.steer)
          report_error($sformatf("steer_value got %0d want %0d", steer_value_o, want.steer));
      end
    end
  end

  task automatic send_position(logic [PosWidth-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    drive_q.push_back(predict_drive(pos));
    samples_sent++;
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (drive_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    if (drive_q.size() != 0) begin
      report_error($sformatf("%0d results never arrived", drive_q.size()));
      drive_q.delete();
    end
    // pipeline is three deep
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, int unsigned val);
    int unsigned mask, kept;
    logic [ApbDataWidth-1:0] junk;
    case (idx)
      RegGainProp:  mask = (1 << GainPropWidth) - 1;
      RegGainInteg: mask = (1 << GainIntegWidth) - 1;
      RegGainDeriv: mask = (1 << GainDerivWidth) - 1;
      default:      mask = (1 << BaseWidth) - 1;
    endcase
    kept = val & mask;
    junk = $urandom;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (junk & ~mask) | kept;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegGainProp:  kp   = kept[GainPropWidth-1:0];
      RegGainInteg: ki   = kept[GainIntegWidth-1:0];
      RegGainDeriv: kd   = kept[GainDerivWidth-1:0];
      default:      base = kept[BaseWidth-1:0];
    endcase
    // read back straight after the write
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept)
      report_error($sformatf("register %s read %0h want %0h", idx.name(), prdata, kept));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_set(int unsigned p, int unsigned i, int unsigned d, int unsigned b);
    stop_requests();
    wait_drained();
    cfg_write(RegGainProp, p);
    cfg_write(RegGainInteg, i);
    cfg_write(RegGainDeriv, d);
    cfg_write(RegBaseSpeed, b);
    gain_settings++;
  endtask

  task automatic set_idling(int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  // mix of noise, long one-sided runs that drive the integral into its limit,
  // and a wandering line with dropouts
  task automatic test_random_track(int n);
    int sent, seg, len, pos, level;
    sent = 0;
    pos = 0;
    while (sent < n) begin
      seg = $urandom_range(9);
      len = $urandom_range(8, 40);
      if (seg < 2) begin
        repeat (len) send_position(PosWidth'($urandom));
      end else if (seg < 4) begin
        level = $urandom_range(1) ? $urandom_range(80, 126) : -$urandom_range(80, 128);
        repeat (len) begin
          if ($urandom_range(9) == 0) send_position(NoLineCode);
          else send_position(PosWidth'(level));
        end
      end else begin
        repeat (len) begin
          pos = pos + $urandom_range(16) - 8;
          if (pos > 126) pos = 126;
          if (pos < -128) pos = -128;
          if ($urandom_range(9) == 0) send_position(NoLineCode);
          else send_position(PosWidth'(pos));
        end
      end
      sent += len;
    end
  endtask

  task automatic test_directed();
    logic [PosWidth-1:0] run [16] = '{8'h7F, 8'h7F, 8'h80, 8'h80, 8'h80, 8'h7E, 8'h7E, 8'h7E,
                                      8'h7F, 8'h7F, 8'h00, 8'h01, 8'hFF, 8'h40, 8'hC0, 8'h7F};
    set_idling(0, 0);
    // starts with no line before any good sample
    foreach (run[k]) send_position(run[k]);
    cfg_set(4095, 1023, 16383, 255);
    send_position(8'h80);
    send_position(8'h7E);
    send_position(8'h80);
    send_position(8'h7F);
    cfg_set(0, 0, 0, 0);
    send_position(8'h55);
    send_position(8'hAA);
    send_position(8'h7F);
  endtask

  task automatic test_gain_extremes();
    set_idling(38, 38);
    cfg_set(4095, 1023, 16383, 0);
    test_random_track(40);
    cfg_set(2304, 768, 12800, 128);
    test_random_track(40);
    cfg_set(0, 768, 0, 200);
    test_random_track(40);
    cfg_set(0, 0, 12800, 50);
    test_random_track(40);
    cfg_set(2304, 0, 0, 255);
    test_random_track(40);
    cfg_set(0, 0, 0, 255);
    test_random_track(40);
    cfg_set(GainPropReset, GainIntegReset, GainDerivReset, BaseSpeedReset);
    test_random_track(40);
  endtask

  task automatic test_drain_pause();
    set_idling(0, 65);
    repeat (3) begin
      test_random_track(30);
      // hold the sender off until the output side is empty
      stop_requests();
      wait_drained();
    end
  endtask

  task automatic test_random_idling();
    int idles [4]  = '{0, 65, 0, 38};
    int stalls [4] = '{0, 0, 65, 38};
    foreach (idles[k]) begin
      cfg_set($urandom_range(2304), $urandom_range(768), $urandom_range(12800),
              $urandom_range(255));
      set_idling(idles[k], stalls[k]);
      test_random_track(220);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_gain_extremes();
    test_drain_pause();
    test_random_idling();
    stop_requests();
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("tb: %0d position samples sent, %0d drive results checked, %0d gain settings",
             samples_sent, results_checked, gain_settings);
    $display("tb: covered no-line holds, integral limits, duty clamps and handshake stalls");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: timed out");
    $display("tb: done, errors");
    $finish;
  end

endmodule
